### design/cml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cml_pkg: shared types and constants of the controller mapping learner
// Opcodes, phase and kind codes, register indexes and the structs that pass
// between the learner's units.
// ----------------------------------------------------------------------------
package cml_pkg;

  // report geometry
  localparam int unsigned REPORT_MAX   = 8;
  localparam int unsigned OFFSET_W     = 3;
  localparam int unsigned STEP_W       = 3;

  // default parameter values
  localparam int unsigned DEF_REPORT_BYTES = 8;
  localparam int unsigned DEF_STEP_COUNT   = 6;

  // register file
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TARGET_W   = 16;
  localparam int unsigned MARGIN_W   = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IDLE_SAMPLE_TARGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER_MARGIN      = 1'b1;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd2000;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 7'd2;

  typedef logic [7:0] byte_t;

  localparam byte_t BYTE_MAX = 8'hFF;
  localparam byte_t BYTE_MIN = 8'h00;

  // request opcodes
  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_ABORT  = 2'd2;

  // phase codes
  localparam logic [1:0] PHASE_INACTIVE = 2'd0;
  localparam logic [1:0] PHASE_SCAN     = 2'd1;
  localparam logic [1:0] PHASE_PRESS    = 2'd2;
  localparam logic [1:0] PHASE_RELEASE  = 2'd3;

  // mapping kinds
  localparam logic [1:0] KIND_NEG_AXIS = 2'd0;
  localparam logic [1:0] KIND_POS_AXIS = 2'd1;
  localparam logic [1:0] KIND_BUTTON   = 2'd2;

  // control from the sequencer to the idle range store
  typedef struct packed {
    logic clear;
    logic sample;
    logic margin;
  } range_ctrl_t;

  // outcome of the deviation search
  typedef struct packed {
    logic                hit;
    logic [OFFSET_W-1:0] offset;
    logic [1:0]          kind;
    byte_t               threshold;
  } match_t;

endpackage

### design/cml_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cml_if: request, result and register channels of the mapping learner
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface cml_item_if;
  import cml_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  byte_t      report_byte_0;
  byte_t      report_byte_1;
  byte_t      report_byte_2;
  byte_t      report_byte_3;
  byte_t      report_byte_4;
  byte_t      report_byte_5;
  byte_t      report_byte_6;
  byte_t      report_byte_7;

  modport source (output valid, op, report_byte_0, report_byte_1, report_byte_2,
                  report_byte_3, report_byte_4, report_byte_5, report_byte_6,
                  report_byte_7, input ready);
  modport sink   (input valid, op, report_byte_0, report_byte_1, report_byte_2,
                  report_byte_3, report_byte_4, report_byte_5, report_byte_6,
                  report_byte_7, output ready);
endinterface

interface cml_result_if;
  import cml_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          phase;
  logic [STEP_W-1:0]   step_index;
  logic                map_valid;
  logic [OFFSET_W-1:0] map_offset;
  logic [1:0]          map_kind;
  byte_t               map_threshold;
  logic                learning_done;
  logic                learning_aborted;

  modport source (output valid, phase, step_index, map_valid, map_offset, map_kind,
                  map_threshold, learning_done, learning_aborted, input ready);
  modport sink   (input valid, phase, step_index, map_valid, map_offset, map_kind,
                  map_threshold, learning_done, learning_aborted, output ready);
endinterface

interface cml_cfg_if;
  import cml_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/cml_range_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cml_range_store: per-byte idle minimum and maximum
// Clears, widens with a sampled report and applies the jitter margin.
// ----------------------------------------------------------------------------
module cml_range_store #(
  parameter int unsigned REPORT_BYTES = cml_pkg::DEF_REPORT_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cml_pkg::range_ctrl_t              ctrl_i,
  input  cml_pkg::byte_t                    bytes_i [cml_pkg::REPORT_MAX],
  input  logic [cml_pkg::MARGIN_W-1:0]      margin_i,
  output cml_pkg::byte_t                    low_o   [REPORT_BYTES],
  output cml_pkg::byte_t                    high_o  [REPORT_BYTES]
);
  import cml_pkg::*;

  byte_t low_q  [REPORT_BYTES];
  byte_t high_q [REPORT_BYTES];
  byte_t low_d  [REPORT_BYTES];
  byte_t high_d [REPORT_BYTES];
  byte_t margin;
  byte_t high_limit;

  assign margin     = {1'b0, margin_i};
  assign high_limit = BYTE_MAX - margin;

  always_comb begin
    for (int i = 0; i < REPORT_BYTES; i++) begin
      low_d[i]  = low_q[i];
      high_d[i] = high_q[i];
      if (ctrl_i.clear) begin
        low_d[i]  = BYTE_MAX;
        high_d[i] = BYTE_MIN;
      end else if (ctrl_i.sample) begin
        if (bytes_i[i] < low_q[i])  low_d[i]  = bytes_i[i];
        if (bytes_i[i] > high_q[i]) high_d[i] = bytes_i[i];
        // last sample: open the range by the margin where it fits
        if (ctrl_i.margin) begin
          if (low_d[i] > margin)      low_d[i]  = low_d[i] - margin;
          if (high_d[i] < high_limit) high_d[i] = high_d[i] + margin;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REPORT_BYTES; i++) begin
        low_q[i]  <= BYTE_MAX;
        high_q[i] <= BYTE_MIN;
      end
    end else begin
      for (int i = 0; i < REPORT_BYTES; i++) begin
        low_q[i]  <= low_d[i];
        high_q[i] <= high_d[i];
      end
    end
  end

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

### design/cml_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cml_match: deviation search and mapping classification
// Picks the lowest byte outside its idle range and classifies it.
// ----------------------------------------------------------------------------
module cml_match #(
  parameter int unsigned REPORT_BYTES = cml_pkg::DEF_REPORT_BYTES
) (
  input  cml_pkg::byte_t  bytes_i [cml_pkg::REPORT_MAX],
  input  cml_pkg::byte_t  low_i   [REPORT_BYTES],
  input  cml_pkg::byte_t  high_i  [REPORT_BYTES],
  output cml_pkg::match_t match_o
);
  import cml_pkg::*;

  logic [OFFSET_W-1:0] pick;
  logic                hit;
  logic [8:0]          sum;
  byte_t               mid;
  byte_t               val;

  // lowest deviating offset wins
  always_comb begin
    hit  = 1'b0;
    pick = '0;
    for (int i = REPORT_BYTES - 1; i >= 0; i--) begin
      if (bytes_i[i] < low_i[i] || bytes_i[i] > high_i[i]) begin
        hit  = 1'b1;
        pick = OFFSET_W'(i);
      end
    end
  end

  assign val = bytes_i[pick];
  assign sum = {1'b0, low_i[pick]} + {1'b0, high_i[pick]};
  assign mid = sum[8:1];

  always_comb begin
    match_o = '0;
    if (hit) begin
      match_o.hit    = 1'b1;
      match_o.offset = pick;
      if (val < mid) begin
        match_o.kind      = KIND_NEG_AXIS;
        match_o.threshold = mid;
      end else if (val > mid) begin
        match_o.kind      = KIND_POS_AXIS;
        match_o.threshold = mid;
      end else begin
        match_o.kind      = KIND_BUTTON;
        match_o.threshold = val;
      end
    end
  end

endmodule

### design/controller_mapping_learner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controller_mapping_learner_unit: learns a controller mapping from reports
// Idle range scan, then one captured control per step, with abort support.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output register can
// drain, and gives one result for each. A request is held in an input
// register, the learner state is updated from it and the result is loaded
// into the output register once that register can take it; the rate is set
// by the single pass through the byte compares and priority pick between
// those two registers. Both sides may stall freely: the input register keeps
// taking requests as long as the output register can drain.
// A start request clears the idle ranges and begins a scan of
// idle_sample_target reports; the jitter margin is applied on the last one.
// Each of STEP_COUNT steps then captures the first report that leaves the
// idle range and waits for a fully idle report. Registers may be written only
// while no request is in flight; reset sets all but the data registers directly.
// ----------------------------------------------------------------------------
module controller_mapping_learner_unit #(
  parameter int unsigned REPORT_BYTES = cml_pkg::DEF_REPORT_BYTES,
  parameter int unsigned STEP_COUNT   = cml_pkg::DEF_STEP_COUNT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cml_item_if.sink     item_i,
  cml_result_if.source result_o,
  cml_cfg_if.sink      cfg_i
);
  import cml_pkg::*;

  // register file
  logic [TARGET_W-1:0] target_q;
  logic [MARGIN_W-1:0] margin_q;

  // input register
  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  byte_t      s1_bytes_q [REPORT_MAX];
  logic       advance;

  // learner state
  logic [TARGET_W-1:0] samples_q, samples_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                await_q, await_d;
  logic                active_q, active_d;

  // result register
  logic                out_valid_q;
  logic [1:0]          phase_q, phase_d;
  match_t              map_q, map_d;
  logic                done_q, done_d;
  logic                aborted_q, aborted_d;

  range_ctrl_t         range_ctrl;
  byte_t               low  [REPORT_BYTES];
  byte_t               high [REPORT_BYTES];
  match_t              match;
  logic [TARGET_W-1:0] samples_inc;
  logic [STEP_W-1:0]   step_inc;
  logic                scanning;

  // configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
      margin_q <= MARGIN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IDLE_SAMPLE_TARGET: target_q <= cfg_i.data;
        REG_JITTER_MARGIN:      margin_q <= cfg_i.data[MARGIN_W-1:0];
        default:                ;
      endcase
    end
  end

  // the input register moves on whenever the result register can take it
  assign advance      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      s1_op_q       <= item_i.op;
      s1_bytes_q[0] <= item_i.report_byte_0;
      s1_bytes_q[1] <= item_i.report_byte_1;
      s1_bytes_q[2] <= item_i.report_byte_2;
      s1_bytes_q[3] <= item_i.report_byte_3;
      s1_bytes_q[4] <= item_i.report_byte_4;
      s1_bytes_q[5] <= item_i.report_byte_5;
      s1_bytes_q[6] <= item_i.report_byte_6;
      s1_bytes_q[7] <= item_i.report_byte_7;
    end
  end

  cml_range_store #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_range (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (range_ctrl),
    .bytes_i  (s1_bytes_q),
    .margin_i (margin_q),
    .low_o    (low),
    .high_o   (high)
  );

  cml_match #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_match (
    .bytes_i (s1_bytes_q),
    .low_i   (low),
    .high_i  (high),
    .match_o (match)
  );

  assign samples_inc = samples_q + TARGET_W'(1);
  assign step_inc    = step_q + STEP_W'(1);
  assign scanning    = samples_q < target_q;

  // sequencer: one request updates the state in a single pass
  always_comb begin
    samples_d  = samples_q;
    step_d     = step_q;
    await_d    = await_q;
    active_d   = active_q;
    range_ctrl = '0;
    map_d      = '0;
    done_d     = 1'b0;
    aborted_d  = 1'b0;
    if (advance) begin
      case (s1_op_q)
        OP_START: begin
          range_ctrl.clear = 1'b1;
          samples_d        = '0;
          step_d           = '0;
          await_d          = 1'b0;
          active_d         = 1'b1;
        end
        OP_ABORT: begin
          if (active_q) begin
            active_d  = 1'b0;
            await_d   = 1'b0;
            aborted_d = 1'b1;
          end
        end
        OP_REPORT: begin
          if (active_q) begin
            if (scanning) begin
              // widen the idle range, margin on the last sample
              range_ctrl.sample = 1'b1;
              range_ctrl.margin = samples_inc == target_q;
              samples_d         = samples_inc;
            end else if (!await_q) begin
              if (match.hit) begin
                map_d   = match;
                await_d = 1'b1;
              end
            end else if (!match.hit) begin
              // idle again: next step
              await_d = 1'b0;
              step_d  = step_inc;
              if (step_inc >= STEP_W'(STEP_COUNT)) begin
                active_d = 1'b0;
                done_d   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // phase as seen after the request
  always_comb begin
    phase_d = PHASE_INACTIVE;
    if (active_d) begin
      if (samples_d < target_q) phase_d = PHASE_SCAN;
      else if (await_d)         phase_d = PHASE_RELEASE;
      else                      phase_d = PHASE_PRESS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= '0;
      step_q    <= '0;
      await_q   <= 1'b0;
      active_q  <= 1'b0;
    end else begin
      samples_q <= samples_d;
      step_q    <= step_d;
      await_q   <= await_d;
      active_q  <= active_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      phase_q   <= phase_d;
      map_q     <= map_d;
      done_q    <= done_d;
      aborted_q <= aborted_d;
    end
  end

  // step index is sampled with the rest of the result
  logic [STEP_W-1:0] step_out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      step_out_q <= step_d;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.phase            = phase_q;
  assign result_o.step_index       = step_out_q;
  assign result_o.map_valid        = map_q.hit;
  assign result_o.map_offset       = map_q.offset;
  assign result_o.map_kind         = map_q.kind;
  assign result_o.map_threshold    = map_q.threshold;
  assign result_o.learning_done    = done_q;
  assign result_o.learning_aborted = aborted_q;

endmodule

### sim/controller_mapping_learner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controller_mapping_learner_unit_tb: self-checking bench of the mapping learner
// Drives start, abort and report requests through the valid/ready channels.
// A cycle-free model of the learner predicts each status result, and a checker
// compares the results in order. A short directed part covers the corner
// cases. Random learning sessions with idle bursts on both sides follow.
// ----------------------------------------------------------------------------
module controller_mapping_learner_unit_tb;
  import cml_pkg::*;

  // op code with no function, only reports the status
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned STEPS      = DEF_STEP_COUNT;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CALM_TAIL  = 200;
  localparam int unsigned SHOW_MAX   = 10;

  typedef struct packed {
    logic [1:0]          phase;
    logic [STEP_W-1:0]   step;
    logic                mapped;
    logic [OFFSET_W-1:0] offset;
    logic [1:0]          kind;
    byte_t               threshold;
    logic                done;
    logic                aborted;
  } status_t;

  logic clk_i;
  logic rst_ni;

  cml_item_if   item_bus ();
  cml_result_if result_bus ();
  cml_cfg_if    cfg_bus ();

  controller_mapping_learner_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // model copy of the learner state and registers
  byte_t             range_lo [REPORT_MAX];
  byte_t             range_hi [REPORT_MAX];
  logic [TARGET_W-1:0] samples_seen;
  logic [STEP_W-1:0]   step_now;
  logic              holding;
  logic              learning;
  logic [TARGET_W-1:0] cfg_target;
  logic [MARGIN_W-1:0] cfg_margin;

  // idle level per byte for the random scans
  byte_t scan_base [REPORT_MAX];

  status_t pending_status_q [$];
  int unsigned fail_count;
  int unsigned random_sent;
  bit          gaps_on;
  bit          stalls_on;

  // --------------------------------------------------------------------------
  // clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous ceiling, well above the slowest correct run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // learner model
  // --------------------------------------------------------------------------
  function automatic void clear_ranges();
    for (int i = 0; i < REPORT_MAX; i++) begin
      range_lo[i] = BYTE_MAX;
      range_hi[i] = BYTE_MIN;
    end
  endfunction

  // lowest byte offset outside its idle range, REPORT_MAX when none
  function automatic int lowest_out_of_range(input logic [63:0] rpt);
    byte_t b;
    for (int i = 0; i < REPORT_MAX; i++) begin
      b = rpt[8*i +: 8];
      if (b < range_lo[i] || b > range_hi[i]) return i;
    end
    return REPORT_MAX;
  endfunction

  function automatic status_t advance_learner(input logic [1:0] op, input logic [63:0] rpt);
    status_t s;
    int      k;
    int      mid;
    byte_t   b;
    s = '0;
    if (op == OP_START) begin
      clear_ranges();
      samples_seen = '0;
      step_now     = '0;
      holding      = 1'b0;
      learning     = 1'b1;
    end else if (op == OP_ABORT) begin
      // abort while inactive is ignored
      if (learning) begin
        learning  = 1'b0;
        holding   = 1'b0;
        s.aborted = 1'b1;
      end
    end else if (op == OP_REPORT && learning) begin
      if (samples_seen < cfg_target) begin
        for (int i = 0; i < REPORT_MAX; i++) begin
          b = rpt[8*i +: 8];
          if (b < range_lo[i]) range_lo[i] = b;
          if (b > range_hi[i]) range_hi[i] = b;
        end
        samples_seen = samples_seen + 1'b1;
        // margin only on the sample that meets the target exactly
        if (samples_seen == cfg_target) begin
          for (int i = 0; i < REPORT_MAX; i++) begin
            if (int'(range_lo[i]) > int'(cfg_margin))
              range_lo[i] = range_lo[i] - byte_t'(cfg_margin);
            if (int'(range_hi[i]) < 255 - int'(cfg_margin))
              range_hi[i] = range_hi[i] + byte_t'(cfg_margin);
          end
        end
      end else if (!holding) begin
        k = lowest_out_of_range(rpt);
        if (k < REPORT_MAX) begin
          mid      = (int'(range_lo[k]) + int'(range_hi[k])) >> 1;
          b        = rpt[8*k +: 8];
          s.mapped = 1'b1;
          s.offset = OFFSET_W'(k);
          if (int'(b) < mid) begin
            s.kind      = KIND_NEG_AXIS;
            s.threshold = byte_t'(mid);
          end else if (int'(b) > mid) begin
            s.kind      = KIND_POS_AXIS;
            s.threshold = byte_t'(mid);
          end else begin
            s.kind      = KIND_BUTTON;
            s.threshold = b;
          end
          holding = 1'b1;
        end
      end else if (lowest_out_of_range(rpt) == REPORT_MAX) begin
        holding  = 1'b0;
        step_now = step_now + 1'b1;
        if (step_now >= STEPS) begin
          learning = 1'b0;
          s.done   = 1'b1;
        end
      end
    end
    if (!learning)                  s.phase = PHASE_INACTIVE;
    else if (samples_seen < cfg_target) s.phase = PHASE_SCAN;
    else if (holding)               s.phase = PHASE_RELEASE;
    else                            s.phase = PHASE_PRESS;
    s.step = step_now;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // report builders working from the model's current ranges
  // --------------------------------------------------------------------------
  function automatic logic [63:0] scan_report();
    logic [63:0] rpt;
    int          v;
    for (int i = 0; i < REPORT_MAX; i++) begin
      v = int'(scan_base[i]) + int'($urandom_range(0, 4)) - 2;
      if (v < 0)   v = 0;
      if (v > 255) v = 255;
      rpt[8*i +: 8] = byte_t'(v);
    end
    return rpt;
  endfunction

  // every byte inside its range where the range is not empty
  function automatic logic [63:0] idle_report();
    logic [63:0] rpt;
    for (int i = 0; i < REPORT_MAX; i++) begin
      if (range_lo[i] <= range_hi[i])
        rpt[8*i +: 8] = byte_t'($urandom_range(range_hi[i], range_lo[i]));
      else
        rpt[8*i +: 8] = byte_t'($urandom_range(0, 255));
    end
    return rpt;
  endfunction

  // push byte k out of its range, below or above as the range allows
  function automatic logic [63:0] deviate_byte(input logic [63:0] rpt, input int k);
    logic [63:0] out;
    out = rpt;
    if (range_lo[k] > BYTE_MIN && (range_hi[k] == BYTE_MAX || $urandom_range(0, 1) == 0))
      out[8*k +: 8] = byte_t'($urandom_range(int'(range_lo[k]) - 1, 0));
    else if (range_hi[k] < BYTE_MAX)
      out[8*k +: 8] = byte_t'($urandom_range(255, int'(range_hi[k]) + 1));
    else
      out[8*k +: 8] = byte_t'($urandom_range(0, 255));
    return out;
  endfunction

  function automatic logic [63:0] pressed_report();
    logic [63:0] rpt;
    rpt = deviate_byte(idle_report(), $urandom_range(0, REPORT_MAX - 1));
    // a second moved byte checks the lowest offset wins
    if ($urandom_range(0, 3) == 0)
      rpt = deviate_byte(rpt, $urandom_range(0, REPORT_MAX - 1));
    return rpt;
  endfunction

  // --------------------------------------------------------------------------
  // channel drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] op, input logic [63:0] rpt);
    status_t want;
    int      n;
    // optional idle burst before the request
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk_i);
      item_bus.valid = 1'b0;
      repeat (n) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    item_bus.op            = op;
    item_bus.report_byte_0 = rpt[7:0];
    item_bus.report_byte_1 = rpt[15:8];
    item_bus.report_byte_2 = rpt[23:16];
    item_bus.report_byte_3 = rpt[31:24];
    item_bus.report_byte_4 = rpt[39:32];
    item_bus.report_byte_5 = rpt[47:40];
    item_bus.report_byte_6 = rpt[55:48];
    item_bus.report_byte_7 = rpt[63:56];
    item_bus.valid         = 1'b1;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    // request taken at this edge
    want = advance_learner(op, rpt);
    pending_status_q.push_back(want);
    random_sent++;
  endtask

  // wait for every pending result, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    item_bus.valid = 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    cfg_bus.valid = 1'b1;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    if (idx == REG_IDLE_SAMPLE_TARGET) cfg_target = data[TARGET_W-1:0];
    else                               cfg_margin = data[MARGIN_W-1:0];
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // margin writes carry junk above the register width
  task automatic set_learning_regs(input int target, input int margin);
    write_reg(REG_IDLE_SAMPLE_TARGET, CFG_DATA_W'(target));
    write_reg(REG_JITTER_MARGIN,
              {CFG_DATA_W'($urandom_range(0, 511)) << MARGIN_W} | CFG_DATA_W'(margin));
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------
  initial begin
    int n;
    result_bus.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 7);
        result_bus.ready = 1'b0;
        repeat (n) @(negedge clk_i);
        result_bus.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready) begin
      got.phase     = result_bus.phase;
      got.step      = result_bus.step_index;
      got.mapped    = result_bus.map_valid;
      got.offset    = result_bus.map_offset;
      got.kind      = result_bus.map_kind;
      got.threshold = result_bus.map_threshold;
      got.done      = result_bus.learning_done;
      got.aborted   = result_bus.learning_aborted;
      if (pending_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_MAX)
          $display("%0t: status result with no request pending: %p", $realtime, got);
      end else begin
        want = pending_status_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= SHOW_MAX) begin
            $display("%0t: status mismatch", $realtime);
            $display("  expected phase %0d step %0d map %0b off %0d kind %0d thr %02h done %0b abt %0b",
                     want.phase, want.step, want.mapped, want.offset, want.kind,
                     want.threshold, want.done, want.aborted);
            $display("  actual   phase %0d step %0d map %0b off %0d kind %0d thr %02h done %0b abt %0b",
                     got.phase, got.step, got.mapped, got.offset, got.kind,
                     got.threshold, got.done, got.aborted);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // directed tests
  // --------------------------------------------------------------------------

  // requests while inactive, then the reset register values in use
  task automatic test_inactive_and_defaults();
    send_item(OP_REPORT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_ABORT,  64'h0000_0000_0000_0000);
    send_item(OP_UNUSED, 64'h0000_0000_0000_0000);
    // default target keeps this in the scan phase
    send_item(OP_START,  64'h0123_4567_89AB_CDEF);
    send_item(OP_REPORT, 64'h8080_8080_8080_8080);
    send_item(OP_ABORT,  64'hFFFF_FFFF_FFFF_FFFF);
    drain();
  endtask

  // short scan with bytes at the limits, captures, unused op and a restart
  task automatic test_scan_and_capture();
    set_learning_regs(3, 2);
    send_item(OP_START,  64'h0000_0000_0000_0000);
    // byte 0 at zero and byte 1 at full scale, bytes 2 and 3 on the margin edge
    send_item(OP_REPORT, 64'h4241_4040_02FD_FF00);
    send_item(OP_REPORT, 64'h4042_4141_02FD_FF00);
    send_item(OP_REPORT, 64'h4140_4240_02FD_FF00);
    // byte 4 pulled low: negative axis
    send_item(OP_REPORT, 64'h4040_4010_02FD_FF00);
    send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_REPORT, 64'h4040_4040_02FD_FF00);
    // byte 7 pushed high: positive axis
    send_item(OP_REPORT, 64'hFF40_4040_02FD_FF00);
    // start while active restarts from step zero
    send_item(OP_START,  64'hFF40_4040_02FD_FF00);
    drain();
  endtask

  // target lowered while the scan is under way ends it with no margin
  task automatic test_lowered_target();
    set_learning_regs(10, 5);
    send_item(OP_START,  64'h0000_0000_0000_0000);
    send_item(OP_REPORT, 64'h1010_1010_1010_1010);
    send_item(OP_REPORT, 64'h1111_1111_1111_1111);
    drain();
    write_reg(REG_IDLE_SAMPLE_TARGET, 16'd1);
    send_item(OP_REPORT, 64'h1111_1111_1111_1120);
    drain();
  endtask

  // zero target: every byte deviates, midpoint value reads as a button
  task automatic test_zero_target();
    set_learning_regs(0, 0);
    send_item(OP_START,  64'h0000_0000_0000_0000);
    send_item(OP_REPORT, 64'h0000_0000_0000_007F);
    send_item(OP_ABORT,  64'h0000_0000_0000_0000);
    drain();
  endtask

  // widest register values
  task automatic test_register_extremes();
    set_learning_regs(65535, 127);
    send_item(OP_START,  64'h0000_0000_0000_0000);
    send_item(OP_REPORT, 64'h0000_00FF_FF00_8080);
    send_item(OP_ABORT,  64'h0000_0000_0000_0000);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // random learning sessions
  // --------------------------------------------------------------------------
  task automatic noise_item();
    send_item(2'($urandom_range(0, 3)),
              {32'($urandom()), 32'($urandom())});
  endtask

  task automatic run_session();
    int target;
    int margin;
    int pick;
    int extra;
    // registers only between sessions, with the block drained
    drain();
    pick = $urandom_range(0, 99);
    if (pick < 5)       target = 0;
    else if (pick < 85) target = $urandom_range(1, 6);
    else                target = $urandom_range(7, 30);
    pick = $urandom_range(0, 9);
    if (pick < 2)      margin = 0;
    else if (pick < 4) margin = 127;
    else if (pick < 8) margin = $urandom_range(0, 8);
    else               margin = $urandom_range(0, 127);
    set_learning_regs(target, margin);
    gaps_on   = (random_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
    stalls_on = (random_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);

    for (int i = 0; i < REPORT_MAX; i++) scan_base[i] = byte_t'($urandom_range(0, 255));
    send_item(OP_START, {32'($urandom()), 32'($urandom())});

    // idle scan, sometimes cut short by a lower target
    while (learning && samples_seen < cfg_target) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      else send_item(OP_REPORT, scan_report());
      if (learning && samples_seen > 0 && $urandom_range(0, 29) == 0) begin
        drain();
        write_reg(REG_IDLE_SAMPLE_TARGET, CFG_DATA_W'($urandom_range(1, samples_seen)));
      end
    end

    // press and release for each step
    for (int s = 0; s < STEPS && learning; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(OP_ABORT, {32'($urandom()), 32'($urandom())});
        break;
      end else if (pick < 7) begin
        send_item(OP_START, {32'($urandom()), 32'($urandom())});
        break;
      end
      if ($urandom_range(0, 9) == 0) send_item(OP_REPORT, idle_report());
      if ($urandom_range(0, 9) < 8) send_item(OP_REPORT, pressed_report());
      else noise_item();
      extra = $urandom_range(0, 2);
      repeat (extra) begin
        if (!learning) break;
        if ($urandom_range(0, 1) == 0) send_item(OP_REPORT, pressed_report());
        else send_item(OP_UNUSED, {32'($urandom()), 32'($urandom())});
      end
      if (learning) send_item(OP_REPORT, idle_report());
    end
    // leftover sessions, e.g. zero target, are ended by an abort now and then
    if (learning && $urandom_range(0, 1) == 0)
      send_item(OP_ABORT, {32'($urandom()), 32'($urandom())});
  endtask

  task automatic test_random_sessions();
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) run_session();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                 = 1'b0;
    item_bus.valid         = 1'b0;
    item_bus.op            = OP_REPORT;
    item_bus.report_byte_0 = BYTE_MIN;
    item_bus.report_byte_1 = BYTE_MIN;
    item_bus.report_byte_2 = BYTE_MIN;
    item_bus.report_byte_3 = BYTE_MIN;
    item_bus.report_byte_4 = BYTE_MIN;
    item_bus.report_byte_5 = BYTE_MIN;
    item_bus.report_byte_6 = BYTE_MIN;
    item_bus.report_byte_7 = BYTE_MIN;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_IDLE_SAMPLE_TARGET;
    cfg_bus.data           = '0;
    fail_count             = 0;
    random_sent            = 0;
    gaps_on                = 1'b1;
    stalls_on              = 1'b1;

    // model reset state
    clear_ranges();
    samples_seen = '0;
    step_now     = '0;
    holding      = 1'b0;
    learning     = 1'b0;
    cfg_target   = TARGET_RESET;
    cfg_margin   = MARGIN_RESET;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_inactive_and_defaults();
    test_scan_and_capture();
    test_lowered_target();
    test_zero_target();
    test_register_extremes();
    test_random_sessions();
    drain();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
